### hdl/wsfd_pkg.sv
package wsfd_pkg;

   localparam int unsigned StatusLen = 12;

   localparam logic [31:0] DefaultMaxPayload = 32'd16777216;

   localparam logic [7:0] ByteCr       = 8'h0D;
   localparam logic [7:0] ByteLf       = 8'h0A;
   localparam logic [7:0] FinBit       = 8'h80;
   localparam logic [7:0] MaskBit      = 8'h80;
   localparam logic [7:0] OpcodeMask   = 8'h0F;
   localparam logic [7:0] LengthMask   = 8'h7F;
   localparam logic [6:0] LenCode16    = 7'd126;
   localparam logic [6:0] LenCode64    = 7'd127;

   localparam logic [3:0] OpContinue = 4'h0;
   localparam logic [3:0] OpText     = 4'h1;
   localparam logic [3:0] OpClose    = 4'h8;
   localparam logic [3:0] OpPing     = 4'h9;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_TEXT = 2'd1,
      KIND_PING = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_HANDSHAKE = 2'd1,
      FAULT_CLOSE     = 2'd2,
      FAULT_OVERSIZE  = 2'd3
   } fault_type;

   // expected start of the upgrade reply: "HTTP/1.1 101"
   function automatic logic [7:0] status_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h48;
         4'd1:    c = 8'h54;
         4'd2:    c = 8'h54;
         4'd3:    c = 8'h50;
         4'd4:    c = 8'h2F;
         4'd5:    c = 8'h31;
         4'd6:    c = 8'h2E;
         4'd7:    c = 8'h31;
         4'd8:    c = 8'h20;
         4'd9:    c = 8'h31;
         4'd10:   c = 8'h30;
         4'd11:   c = 8'h31;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### hdl/websocket_frame_deframer_top.sv
// Client-side websocket receiver, one byte per transaction. It first checks the
// http upgrade reply (status line "HTTP/1.1 101", headers ended by a blank line),
// then parses frames: fin, opcode, 7/16/64-bit length and optional mask key,
// unmasking payload bytes as they pass. Every accepted byte gives exactly one
// result in the next cycle, and a new byte is taken in every cycle: the whole
// per-byte state update is a single pass of logic into the result register, so
// the only stall is a result still waiting in that register while rsp_ready is
// low. A transaction with req_new_connection set clears all parsing state (not
// max_payload_len) and returns an all-zero result. After any fault every byte
// gives an all-zero result until a new connection.
module websocket_frame_deframer_top (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 req_new_connection,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_data_byte,
   output wsfd_pkg::kind_type   rsp_data_kind,
   output logic                 rsp_message_restart,
   output logic                 rsp_message_end,
   output logic                 rsp_ping_end,
   output logic                 rsp_handshake_ok,
   output wsfd_pkg::fault_type  rsp_fault,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [31:0]          csr_max_payload_len
);
   import wsfd_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADERS = 3'd0,
      PH_B0      = 3'd1,
      PH_B1      = 3'd2,
      PH_EXTLEN  = 3'd3,
      PH_MASK    = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_FAULTED = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        status_ok_ff, status_ok_in;
   logic [3:0]  status_pos_ff, status_pos_in;
   logic [1:0]  blank_ff, blank_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [63:0] length_ff, length_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_idx_ff, mask_idx_in;
   logic [31:0] payload_left_ff, payload_left_in;
   logic        text_started_ff, text_started_in;
   logic [31:0] max_len_ff;

   logic        rsp_valid_ff;
   logic [7:0]  data_byte_ff, data_byte_in;
   kind_type    data_kind_ff, data_kind_in;
   logic        restart_ff, restart_in;
   logic        msg_end_ff, msg_end_in;
   logic        ping_end_ff, ping_end_in;
   logic        hs_ok_ff, hs_ok_in;
   fault_type   fault_ff, fault_in;

   logic        req_take;
   logic        len_known;
   logic        hdr_done;
   logic        frm_done;
   logic [7:0]  unmasked;
   logic [31:0] payload_dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign payload_dec = payload_left_ff - 32'd1;
   assign unmasked    = masked_ff ?
                        (req_rx_byte ^ mask_key_ff[{mask_idx_ff, 3'b000} +: 8]) :
                        req_rx_byte;

   always_comb begin
      phase_in        = phase_ff;
      status_ok_in    = status_ok_ff;
      status_pos_in   = status_pos_ff;
      blank_in        = blank_ff;
      fin_in          = fin_ff;
      opcode_in       = opcode_ff;
      masked_in       = masked_ff;
      length_in       = length_ff;
      ext_left_in     = ext_left_ff;
      mask_key_in     = mask_key_ff;
      mask_idx_in     = mask_idx_ff;
      payload_left_in = payload_left_ff;
      text_started_in = text_started_ff;

      data_byte_in = 8'h00;
      data_kind_in = KIND_NONE;
      restart_in   = 1'b0;
      msg_end_in   = 1'b0;
      ping_end_in  = 1'b0;
      hs_ok_in     = 1'b0;
      fault_in     = FAULT_NONE;

      len_known = 1'b0;
      hdr_done  = 1'b0;
      frm_done  = 1'b0;

      if (req_new_connection) begin
         phase_in        = PH_HEADERS;
         status_ok_in    = 1'b1;
         status_pos_in   = 4'd0;
         blank_in        = 2'd0;
         fin_in          = 1'b0;
         opcode_in       = 4'h0;
         masked_in       = 1'b0;
         length_in       = 64'd0;
         ext_left_in     = 4'd0;
         mask_key_in     = 32'd0;
         mask_idx_in     = 2'd0;
         payload_left_in = 32'd0;
         text_started_in = 1'b0;
      end else begin
         case (phase_ff)
            PH_HEADERS: begin
               if (status_pos_ff < 4'(StatusLen)) begin
                  if (req_rx_byte != status_char(status_pos_ff)) status_ok_in = 1'b0;
                  status_pos_in = status_pos_ff + 4'd1;
               end
               if (blank_ff == 2'd3 && req_rx_byte == ByteLf) begin
                  if (status_ok_in && status_pos_in == 4'(StatusLen)) begin
                     hs_ok_in = 1'b1;
                     phase_in = PH_B0;
                  end else begin
                     fault_in = FAULT_HANDSHAKE;
                     phase_in = PH_FAULTED;
                  end
                  blank_in = 2'd0;
               end else if (!blank_ff[0]) begin
                  blank_in = (req_rx_byte == ByteCr) ? blank_ff + 2'd1 : 2'd0;
               end else begin
                  blank_in = (req_rx_byte == ByteLf) ? blank_ff + 2'd1 :
                             (req_rx_byte == ByteCr) ? 2'd1 : 2'd0;
               end
            end
            PH_B0: begin
               fin_in    = (req_rx_byte & FinBit) != 8'h00;
               opcode_in = 4'(req_rx_byte & OpcodeMask);
               phase_in  = PH_B1;
            end
            PH_B1: begin
               masked_in = (req_rx_byte & MaskBit) != 8'h00;
               length_in = 64'd0;
               if (req_rx_byte[6:0] == LenCode16) begin
                  ext_left_in = 4'd2;
                  phase_in    = PH_EXTLEN;
               end else if (req_rx_byte[6:0] == LenCode64) begin
                  ext_left_in = 4'd8;
                  phase_in    = PH_EXTLEN;
               end else begin
                  length_in = {57'd0, 7'(req_rx_byte & LengthMask)};
                  len_known = 1'b1;
               end
            end
            PH_EXTLEN: begin
               length_in   = {length_ff[55:0], req_rx_byte};
               ext_left_in = ext_left_ff - 4'd1;
               if (ext_left_in == 4'd0) len_known = 1'b1;
            end
            PH_MASK: begin
               mask_key_in[{mask_idx_ff, 3'b000} +: 8] = req_rx_byte;
               mask_idx_in = mask_idx_ff + 2'd1;
               if (mask_idx_in == 2'd0) hdr_done = 1'b1;
            end
            PH_PAYLOAD: begin
               mask_idx_in = mask_idx_ff + 2'd1;
               if (opcode_ff == OpContinue || opcode_ff == OpText) begin
                  data_byte_in = unmasked;
                  data_kind_in = KIND_TEXT;
               end else if (opcode_ff == OpPing) begin
                  data_byte_in = unmasked;
                  data_kind_in = KIND_PING;
               end
               payload_left_in = payload_dec;
               if (payload_dec == 32'd0) frm_done = 1'b1;
            end
            default: phase_in = PH_FAULTED;
         endcase

         // length checked before any mask key
         if (len_known) begin
            if (length_in > {32'd0, max_len_ff}) begin
               fault_in = FAULT_OVERSIZE;
               phase_in = PH_FAULTED;
            end else if (masked_in) begin
               mask_idx_in = 2'd0;
               mask_key_in = 32'd0;
               phase_in    = PH_MASK;
            end else begin
               hdr_done = 1'b1;
            end
         end

         if (hdr_done) begin
            if (opcode_in == OpText) begin
               restart_in      = 1'b1;
               text_started_in = 1'b1;
            end
            mask_idx_in = 2'd0;
            if (length_in == 64'd0) begin
               frm_done = 1'b1;
            end else begin
               payload_left_in = length_in[31:0];
               phase_in        = PH_PAYLOAD;
            end
         end

         // zero-length frames complete on their last header byte
         if (frm_done) begin
            phase_in = PH_B0;
            if (opcode_in == OpContinue || opcode_in == OpText) begin
               if (fin_in && text_started_in) msg_end_in = 1'b1;
            end else if (opcode_in == OpPing) begin
               ping_end_in = 1'b1;
            end else if (opcode_in == OpClose) begin
               fault_in = FAULT_CLOSE;
               phase_in = PH_FAULTED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADERS;
         status_ok_ff    <= 1'b1;
         status_pos_ff   <= 4'd0;
         blank_ff        <= 2'd0;
         fin_ff          <= 1'b0;
         opcode_ff       <= 4'h0;
         masked_ff       <= 1'b0;
         length_ff       <= 64'd0;
         ext_left_ff     <= 4'd0;
         mask_key_ff     <= 32'd0;
         mask_idx_ff     <= 2'd0;
         payload_left_ff <= 32'd0;
         text_started_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         data_byte_ff    <= 8'h00;
         data_kind_ff    <= KIND_NONE;
         restart_ff      <= 1'b0;
         msg_end_ff      <= 1'b0;
         ping_end_ff     <= 1'b0;
         hs_ok_ff        <= 1'b0;
         fault_ff        <= FAULT_NONE;
      end else begin
         if (req_take) begin
            phase_ff        <= phase_in;
            status_ok_ff    <= status_ok_in;
            status_pos_ff   <= status_pos_in;
            blank_ff        <= blank_in;
            fin_ff          <= fin_in;
            opcode_ff       <= opcode_in;
            masked_ff       <= masked_in;
            length_ff       <= length_in;
            ext_left_ff     <= ext_left_in;
            mask_key_ff     <= mask_key_in;
            mask_idx_ff     <= mask_idx_in;
            payload_left_ff <= payload_left_in;
            text_started_ff <= text_started_in;
            rsp_valid_ff    <= 1'b1;
            data_byte_ff    <= data_byte_in;
            data_kind_ff    <= data_kind_in;
            restart_ff      <= restart_in;
            msg_end_ff      <= msg_end_in;
            ping_end_ff     <= ping_end_in;
            hs_ok_ff        <= hs_ok_in;
            fault_ff        <= fault_in;
         end else if (rsp_ready) begin
            rsp_valid_ff    <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= DefaultMaxPayload;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_payload_len;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data_byte       = data_byte_ff;
   assign rsp_data_kind       = data_kind_ff;
   assign rsp_message_restart = restart_ff;
   assign rsp_message_end     = msg_end_ff;
   assign rsp_ping_end        = ping_end_ff;
   assign rsp_handshake_ok    = hs_ok_ff;
   assign rsp_fault           = fault_ff;

endmodule
